// ----- rtl/smpg_pkg.sv -----
// Shared widths, codes and request structs for the sprite motion pattern generator.
`default_nettype none
package smpg_pkg;

    localparam int MODE_BITS    = 3;
    localparam int AMP_BITS     = 16;
    localparam int HP_BITS      = 16;
    localparam int ELAPSED_BITS = 32;
    localparam int DUR_BITS     = 32;
    localparam int PHASE_BITS   = HP_BITS + 1;
    localparam int PROD_BITS    = AMP_BITS + PHASE_BITS;
    localparam int DELTA_BITS   = AMP_BITS + 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [MODE_BITS-1:0] MODE_LINEAR = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_SINE   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_CIRCLE = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_ZIGZAG = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_BOUNCE = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AMP      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DURATION = 2'd3;

    typedef struct packed {
        logic                    start;
        logic [ELAPSED_BITS-1:0] dividend;
        logic [PHASE_BITS-1:0]   dvsr;
    } t_mod_req;

    typedef struct packed {
        logic                  start;
        logic [AMP_BITS-1:0]   amag;
        logic [PHASE_BITS-1:0] mult;
        logic [PHASE_BITS-1:0] dvsr;
    } t_md_req;

endpackage
`default_nettype wire

// ----- rtl/smpg_mod_unit.sv -----
// Bit-serial restoring remainder of the elapsed tick count by the full period.
`default_nettype none
module smpg_mod_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire smpg_pkg::t_mod_req                  i_req,
    output logic                                     o_done,
    output logic [smpg_pkg::PHASE_BITS-1:0]          o_rem
);

    localparam int CNT_BITS = $clog2(smpg_pkg::ELAPSED_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(smpg_pkg::ELAPSED_BITS - 1);

    logic                                  r_busy;
    logic                                  r_done;
    logic [CNT_BITS-1:0]                   r_cnt;
    logic [smpg_pkg::ELAPSED_BITS-1:0]     r_dvd;
    logic [smpg_pkg::PHASE_BITS-1:0]       r_dvsr;
    logic [smpg_pkg::PHASE_BITS-1:0]       r_rem;
    logic [smpg_pkg::PHASE_BITS:0]         w_trial;
    logic                                  w_ge;
    logic [smpg_pkg::PHASE_BITS-1:0]       n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[smpg_pkg::ELAPSED_BITS-1]};
        w_ge    = (w_trial >= {1'b0, r_dvsr});
        n_rem   = w_ge ? smpg_pkg::PHASE_BITS'(w_trial - {1'b0, r_dvsr})
                       : w_trial[smpg_pkg::PHASE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd  <= i_req.dividend;
            r_dvsr <= i_req.dvsr;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[smpg_pkg::ELAPSED_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ----- rtl/smpg_muldiv.sv -----
// Bit-serial shift-add multiply followed by restoring divide of the phase offset.
`default_nettype none
module smpg_muldiv (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire smpg_pkg::t_md_req                i_req,
    output logic                                  o_done,
    output logic [smpg_pkg::AMP_BITS-1:0]         o_quot
);

    localparam int AB = smpg_pkg::AMP_BITS;
    localparam int PB = smpg_pkg::PHASE_BITS;
    localparam int CNT_BITS = $clog2(AB);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(AB - 1);

    logic                                  r_busy;
    logic                                  r_div;
    logic                                  r_done;
    logic [CNT_BITS-1:0]                   r_cnt;
    logic [smpg_pkg::PROD_BITS-1:0]        r_acc;
    logic [AB-1:0]                         r_mb;
    logic [PB-1:0]                         r_mult;
    logic [PB-1:0]                         r_dvsr;
    logic [PB-1:0]                         r_rem;
    logic [AB-1:0]                         r_q;
    logic [smpg_pkg::PROD_BITS-1:0]        n_acc;
    logic [PB:0]                           w_trial;
    logic                                  w_ge;
    logic [PB-1:0]                         n_rem;

    always_comb begin
        n_acc   = {r_acc[smpg_pkg::PROD_BITS-2:0], 1'b0}
                + (r_mb[AB-1] ? smpg_pkg::PROD_BITS'(r_mult) : '0);
        w_trial = {r_rem, r_q[AB-1]};
        w_ge    = (w_trial >= {1'b0, r_dvsr});
        n_rem   = w_ge ? PB'(w_trial - {1'b0, r_dvsr}) : w_trial[PB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_div  <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_div <= ~r_div;
                    if (r_div) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc  <= '0;
            r_mb   <= i_req.amag;
            r_mult <= i_req.mult;
            r_dvsr <= i_req.dvsr;
        end else if (r_busy && !r_div) begin
            r_acc <= n_acc;
            r_mb  <= {r_mb[AB-2:0], 1'b0};
            if (r_cnt == CNT_LAST) begin
                r_rem <= n_acc[smpg_pkg::PROD_BITS-1:AB];
                r_q   <= n_acc[AB-1:0];
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[AB-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ----- rtl/sprite_motion_pattern_generator.sv -----
// Top level of the sprite motion pattern generator: control, config and result register.
//
// Input channel i_valid / o_stall carries one beat per tick: i_kind, i_pos_x, i_pos_y.
// A motion beat (kind 0) moves the position by the configured pattern and advances
// the elapsed tick count; a clear beat (kind 1) zeroes the count and returns the
// position unchanged with finished low.
// Output channel o_valid / i_stall returns exactly one beat per input beat.
// A motion beat runs the bit-serial remainder of elapsed by the period, then the serial
// multiply and divide of the offset, then waits for the output register; a clear beat goes
// straight to the output register. Control steps through the idle, remainder,
// multiply-divide and output states.
// One beat is worked on at a time; o_stall is high from acceptance until its result
// has been moved into the output register.
// The output register holds a result while i_stall is high; work on the next beat
// runs on, and only its hand-off to the output register waits.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so
// only while idle, which the block itself does not enforce. Synchronous reset clears the
// elapsed count, the configuration to its defaults and both channels.
`default_nettype none
module sprite_motion_pattern_generator #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic                                  i_kind,
    input  wire logic [COORD_BITS-1:0]                 i_pos_x,
    input  wire logic [COORD_BITS-1:0]                 i_pos_y,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [COORD_BITS-1:0]                      o_new_x,
    output logic [COORD_BITS-1:0]                      o_new_y,
    output logic                                       o_finished,
    input  wire logic                                  i_cfg_we,
    input  wire logic [smpg_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [smpg_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int AB = smpg_pkg::AMP_BITS;
    localparam int HB = smpg_pkg::HP_BITS;
    localparam int PB = smpg_pkg::PHASE_BITS;
    localparam int DB = smpg_pkg::DELTA_BITS;
    localparam int EB = smpg_pkg::ELAPSED_BITS;
    localparam int SUM_BITS = ((COORD_BITS > DB) ? COORD_BITS : DB) + 1;
    localparam logic [SUM_BITS-1:0] C_MAX =
        (SUM_BITS'(1) << (COORD_BITS - 1)) - SUM_BITS'(1);
    localparam logic [SUM_BITS-1:0] C_MIN = ~C_MAX;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_MD   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                       r_state;
    logic [smpg_pkg::MODE_BITS-1:0]   r_mode;
    logic [AB-1:0]                    r_amp;
    logic [HB-1:0]                    r_half;
    logic [smpg_pkg::DUR_BITS-1:0]    r_dur;
    logic [EB-1:0]                    r_elapsed;
    logic [COORD_BITS-1:0]            r_x;
    logic [COORD_BITS-1:0]            r_y;
    logic                             r_first_half;
    logic                             r_lt_quarter;
    logic [DB-1:0]                    r_dx;
    logic [DB-1:0]                    r_dy;
    logic                             r_fin_next;
    logic                             r_out_valid;
    logic [COORD_BITS-1:0]            r_new_x;
    logic [COORD_BITS-1:0]            r_new_y;
    logic                             r_fin;

    logic                             w_accept;
    logic [HB-1:0]                    w_hp;
    logic [PB-1:0]                    w_hp_ext;
    logic [PB-1:0]                    w_mod_rem_q;
    logic [PB-1:0]                    w_phase;
    logic                             w_first_half;
    smpg_pkg::t_mod_req               w_mod_req;
    smpg_pkg::t_md_req                w_md_req;
    logic                             w_mod_done;
    logic                             w_md_done;
    logic [AB-1:0]                    w_quot;
    logic [DB-1:0]                    w_amp_x;
    logic [DB-1:0]                    w_neg_amp;
    logic [DB-1:0]                    w_q_pos;
    logic [DB-1:0]                    w_q_sgn;
    logic [AB:0]                      w_half_sum;
    logic [DB-1:0]                    w_half_amp;
    logic [DB-1:0]                    n_dx;
    logic [DB-1:0]                    n_dy;
    logic [EB-1:0]                    n_elapsed;
    logic                             w_load_out;
    logic [SUM_BITS-1:0]              w_sum_x;
    logic [SUM_BITS-1:0]              w_sum_y;

    function automatic logic [COORD_BITS-1:0] f_sat(input logic [SUM_BITS-1:0] v);
        logic [COORD_BITS-1:0] res;
        if ($signed(v) > $signed(C_MAX)) begin
            res = C_MAX[COORD_BITS-1:0];
        end else if ($signed(v) < $signed(C_MIN)) begin
            res = C_MIN[COORD_BITS-1:0];
        end else begin
            res = v[COORD_BITS-1:0];
        end
        return res;
    endfunction

    assign w_accept = i_valid && !o_stall;
    assign w_hp     = (r_half == '0) ? HB'(1) : r_half;
    assign w_hp_ext = {1'b0, w_hp};
    assign w_phase  = w_mod_rem_q;

    always_comb begin
        w_mod_req.start    = w_accept && !i_kind;
        w_mod_req.dividend = r_elapsed;
        w_mod_req.dvsr     = {w_hp, 1'b0};

        w_first_half    = (w_phase < w_hp_ext);
        w_md_req.start  = (r_state == S_MOD) && w_mod_done;
        w_md_req.amag   = r_amp[AB-1] ? AB'(~r_amp + 1'b1) : r_amp;
        w_md_req.mult   = '0;
        w_md_req.dvsr   = w_hp_ext;
        unique case (r_mode) inside
            smpg_pkg::MODE_SINE, smpg_pkg::MODE_BOUNCE: begin
                w_md_req.mult = w_first_half ? w_phase : PB'(w_phase - w_hp_ext);
            end
            smpg_pkg::MODE_CIRCLE: begin
                w_md_req.mult = w_phase;
                w_md_req.dvsr = {w_hp, 1'b0};
            end
            default: begin
                w_md_req.mult = '0;
            end
        endcase
    end

    smpg_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem_q)
    );

    smpg_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_done  (w_md_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_amp_x    = {{(DB-AB){r_amp[AB-1]}}, r_amp};
        w_neg_amp  = DB'(0) - w_amp_x;
        w_q_pos    = {{(DB-AB){1'b0}}, w_quot};
        w_q_sgn    = r_amp[AB-1] ? DB'(DB'(0) - w_q_pos) : w_q_pos;
        w_half_sum = {r_amp[AB-1], r_amp} + (AB+1)'(r_amp[AB-1]);
        w_half_amp = {{(DB-AB){w_half_sum[AB]}}, w_half_sum[AB:1]};
        n_dx = '0;
        n_dy = '0;
        unique case (r_mode) inside
            smpg_pkg::MODE_LINEAR: begin
                n_dx = w_amp_x;
            end
            smpg_pkg::MODE_SINE, smpg_pkg::MODE_BOUNCE: begin
                n_dy = r_first_half ? DB'(DB'(0) - w_q_sgn) : w_q_sgn;
            end
            smpg_pkg::MODE_CIRCLE: begin
                n_dx = w_q_sgn;
                n_dy = w_half_amp;
            end
            smpg_pkg::MODE_ZIGZAG: begin
                n_dx = DB'(1);
                n_dy = r_lt_quarter ? w_neg_amp : w_amp_x;
            end
            default: begin
                n_dx = '0;
            end
        endcase
        n_elapsed = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    end

    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || !i_stall);
    assign w_sum_x = {{(SUM_BITS-COORD_BITS){r_x[COORD_BITS-1]}}, r_x}
                   + {{(SUM_BITS-DB){r_dx[DB-1]}}, r_dx};
    assign w_sum_y = {{(SUM_BITS-COORD_BITS){r_y[COORD_BITS-1]}}, r_y}
                   + {{(SUM_BITS-DB){r_dy[DB-1]}}, r_dy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= smpg_pkg::MODE_LINEAR;
            r_amp       <= '0;
            r_half      <= HB'(1);
            r_dur       <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    smpg_pkg::CFG_MODE:     r_mode <= i_cfg_data[smpg_pkg::MODE_BITS-1:0];
                    smpg_pkg::CFG_AMP:      r_amp  <= i_cfg_data[AB-1:0];
                    smpg_pkg::CFG_HALF:     r_half <= i_cfg_data[HB-1:0];
                    smpg_pkg::CFG_DURATION: r_dur  <= i_cfg_data[smpg_pkg::DUR_BITS-1:0];
                endcase
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_kind) begin
                            r_elapsed <= '0;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_state <= S_MD;
                    end
                end
                S_MD: begin
                    if (w_md_done) begin
                        r_elapsed <= n_elapsed;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x        <= i_pos_x;
            r_y        <= i_pos_y;
            r_dx       <= '0;
            r_dy       <= '0;
            r_fin_next <= 1'b0;
        end
        if ((r_state == S_MOD) && w_mod_done) begin
            r_first_half <= w_first_half;
            r_lt_quarter <= (w_phase < PB'(w_hp >> 1));
        end
        if ((r_state == S_MD) && w_md_done) begin
            r_dx       <= n_dx;
            r_dy       <= n_dy;
            r_fin_next <= (r_dur != '0) && (n_elapsed >= r_dur);
        end
        if (w_load_out) begin
            r_new_x <= f_sat(w_sum_x);
            r_new_y <= f_sat(w_sum_y);
            r_fin   <= r_fin_next;
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_new_x    = r_new_x;
    assign o_new_y    = r_new_y;
    assign o_finished = r_fin;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("input accepted but block not busy next cycle");

    a_clear_zeroes_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind) |=> (r_elapsed == '0))
        else $error("clear beat did not zero elapsed count");

    a_elapsed_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_elapsed != $past(r_elapsed)))
            |-> ((r_elapsed == '0) || (r_elapsed == $past(r_elapsed) + 1'b1)))
        else $error("elapsed count moved other than by clear or increment");

    a_md_done_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> (r_state == S_MD))
        else $error("divide finished outside its wait state");

    a_mod_done_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_MOD))
        else $error("remainder finished outside its wait state");

endmodule
`default_nettype wire
